[rtl/dcca_pkg.sv]
// ----------------------------------------------------------------------------
// dcca_pkg
// shared types and constants for the datagram crc32c check and ack unit
// ----------------------------------------------------------------------------
package dcca_pkg;

	localparam int          MAX_DATAGRAM_BYTES_DEF = 2048;
	localparam int          HEADER_BYTES           = 16;
	localparam logic [31:0] CRC_POLY               = 32'h82F6_3B78;
	localparam logic [31:0] ACK_FLAG               = 32'h8000_0000;
	localparam logic [31:0] NOACK_FLAG             = 32'h4000_0000;
	localparam int          OUT_TDATA_W            = 168;

	// verdict codes
	typedef enum logic [2:0] {
		ST_SHORT      = 3'd0,
		ST_TRUNC      = 3'd1,
		ST_CRC_BAD    = 3'd2,
		ST_ACK_RCVD   = 3'd3,
		ST_ACK_NEEDED = 3'd4,
		ST_NOACK      = 3'd5
	} status_t;

	// datagram state as it stands after the final byte
	typedef struct packed {
		logic        is_short;
		logic        is_trunc;
		logic        crc_ok;
		logic [31:0] pid;
		logic [31:0] sid;
		logic [31:0] size;
		logic [31:0] reply_crc;
	} snap_t;

endpackage

[rtl/datagram_crc32c_check_and_ack_unit.sv]
// ----------------------------------------------------------------------------
// datagram_crc32c_check_and_ack_unit
// byte-stream datagram crc-32c check with acknowledgement verdict
// ----------------------------------------------------------------------------
// a final byte is registered at input, then its verdict in the result register
// throughput: 1 byte per cycle; the crc byte step and header capture fit one stage
// a final byte waits in the input register only while a previous verdict is untaken
// reset: arst_n clears input valid, result valid, byte count and crc presets
// after each final byte all datagram state returns to its reset value
// ----------------------------------------------------------------------------
module datagram_crc32c_check_and_ack_unit
	import dcca_pkg::*;
#(
	parameter int MAX_DATAGRAM_BYTES = MAX_DATAGRAM_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,   // data_byte
	input  logic                   s_axis_tlast,   // last
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// status[2:0], pkt_id[34:3], seq_id[66:35], declared_size[98:67],
	// ack_pkt_id[130:99], ack_checksum[162:131], zero fill above
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic       out_free;
	logic       step;
	logic       in_xfer;
	snap_t      snap;

	status_t     status;
	logic [31:0] pkt_id, seq_id, declared_size, ack_pkt_id, ack_checksum;

	// result slot is free when empty or being drained this cycle
	assign out_free = !m_axis_tvalid || m_axis_tready;

	// plain bytes always advance; a final byte needs the result slot
	assign step          = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || step;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// header capture and crc accumulation
	dcca_rx_state #(
		.MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
	) u_rx_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.last      (last_s1),
		.snap      (snap)
	);

	// verdict and result register
	dcca_verdict u_verdict (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (step && last_s1),
		.snap          (snap),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.status        (status),
		.pkt_id        (pkt_id),
		.seq_id        (seq_id),
		.declared_size (declared_size),
		.ack_pkt_id    (ack_pkt_id),
		.ack_checksum  (ack_checksum)
	);

	assign m_axis_tdata = {5'b0, ack_checksum, ack_pkt_id, declared_size,
	                       seq_id, pkt_id, status};

	a_last_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && m_axis_tvalid && !m_axis_tready |=> valid_s1 && last_s1)
		else $error("final byte lost while result stalled");

endmodule

[rtl/dcca_crc_byte.sv]
// ----------------------------------------------------------------------------
// dcca_crc_byte
// one byte of reflected crc-32c, unrolled over eight bit steps
// ----------------------------------------------------------------------------
module dcca_crc_byte
	import dcca_pkg::*;
(
	input  logic [31:0] crc_in,
	input  logic [7:0]  data_byte,
	output logic [31:0] crc_out
);

	always_comb begin
		logic [31:0] r;
		r = crc_in ^ {24'h0, data_byte};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		crc_out = r;
	end

endmodule

[rtl/dcca_rx_state.sv]
// ----------------------------------------------------------------------------
// dcca_rx_state
// byte counter, header capture and the two crc registers
// ----------------------------------------------------------------------------
module dcca_rx_state
	import dcca_pkg::*;
#(
	parameter int MAX_DATAGRAM_BYTES = MAX_DATAGRAM_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       last,
	output snap_t      snap
);

	localparam int CW = $clog2(MAX_DATAGRAM_BYTES + 1);

	logic [CW-1:0] count_q, count_n;
	logic [31:0]   hdr_q [4];
	logic [31:0]   hdr_n [4];
	logic [31:0]   crc_q, crc_n, crc_fed;
	logic [31:0]   reply_q, reply_n, reply_fed;
	logic [7:0]    reply_byte;
	logic [1:0]    idx;
	logic          in_buf, in_hdr, in_payload, feed_crc, feed_reply;

	assign in_buf     = count_q < CW'(MAX_DATAGRAM_BYTES);
	assign in_hdr     = count_q < CW'(HEADER_BYTES);
	assign idx        = count_q[3:2];
	assign in_payload = (32'(count_q) - 32'(HEADER_BYTES)) < hdr_q[3];

	// header bytes 8-11 carry the checksum word and are skipped
	assign feed_crc = in_buf && (in_hdr ? (count_q < CW'(8) || count_q >= CW'(12))
	                                    : in_payload);

	// reply crc: reply bytes 0-7, then the four zero bytes while bytes 8-11 pass
	assign feed_reply = in_buf && (count_q < CW'(12));
	always_comb begin
		if (count_q == '0) begin
			reply_byte = data_byte | 8'h80;
		end else if (count_q < CW'(8)) begin
			reply_byte = data_byte;
		end else begin
			reply_byte = 8'h00;
		end
	end

	dcca_crc_byte u_crc_main (
		.crc_in    (crc_q),
		.data_byte (data_byte),
		.crc_out   (crc_fed)
	);

	dcca_crc_byte u_crc_reply (
		.crc_in    (reply_q),
		.data_byte (reply_byte),
		.crc_out   (reply_fed)
	);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			hdr_n[i] = hdr_q[i];
		end
		if (in_buf && in_hdr) begin
			hdr_n[idx] = {hdr_q[idx][23:0], data_byte};
		end
		count_n = in_buf ? count_q + CW'(1) : count_q;
		crc_n   = feed_crc ? crc_fed : crc_q;
		reply_n = feed_reply ? reply_fed : reply_q;
	end

	// snapshot of the datagram including the byte now being taken
	always_comb begin
		snap.is_short  = count_n < CW'(HEADER_BYTES);
		snap.is_trunc  = (33'(HEADER_BYTES) + {1'b0, hdr_n[3]}) > 33'(count_n);
		snap.crc_ok    = (~crc_n) == hdr_n[2];
		snap.pid       = hdr_n[0];
		snap.sid       = hdr_n[1];
		snap.size      = hdr_n[3];
		snap.reply_crc = reply_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= '1;
			reply_q <= '1;
			for (int i = 0; i < 4; i++) begin
				hdr_q[i] <= '0;
			end
		end else if (step) begin
			if (last) begin
				count_q <= '0;
				crc_q   <= '1;
				reply_q <= '1;
				for (int i = 0; i < 4; i++) begin
					hdr_q[i] <= '0;
				end
			end else begin
				count_q <= count_n;
				crc_q   <= crc_n;
				reply_q <= reply_n;
				for (int i = 0; i < 4; i++) begin
					hdr_q[i] <= hdr_n[i];
				end
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_DATAGRAM_BYTES))
		else $error("byte count beyond buffer size");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> count_q == '0 && crc_q == '1 && reply_q == '1)
		else $error("state not cleared after final byte");

endmodule

[rtl/dcca_verdict.sv]
// ----------------------------------------------------------------------------
// dcca_verdict
// verdict decode and result register
// ----------------------------------------------------------------------------
module dcca_verdict
	import dcca_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  snap_t       snap,
	input  logic        out_ready,
	output logic        out_valid,
	output status_t     status,
	output logic [31:0] pkt_id,
	output logic [31:0] seq_id,
	output logic [31:0] declared_size,
	output logic [31:0] ack_pkt_id,
	output logic [31:0] ack_checksum
);

	status_t status_d;

	always_comb begin
		if (snap.is_short) begin
			status_d = ST_SHORT;
		end else if (snap.is_trunc) begin
			status_d = ST_TRUNC;
		end else if (!snap.crc_ok) begin
			status_d = ST_CRC_BAD;
		end else if ((snap.pid & ACK_FLAG) != '0) begin
			status_d = ST_ACK_RCVD;
		end else if ((snap.pid & NOACK_FLAG) == '0) begin
			status_d = ST_ACK_NEEDED;
		end else begin
			status_d = ST_NOACK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status <= status_d;
			if (snap.is_short) begin
				pkt_id        <= '0;
				seq_id        <= '0;
				declared_size <= '0;
				ack_pkt_id    <= '0;
				ack_checksum  <= '0;
			end else begin
				pkt_id        <= snap.pid;
				seq_id        <= snap.sid;
				declared_size <= snap.size;
				ack_pkt_id    <= snap.pid | ACK_FLAG;
				ack_checksum  <= ~snap.reply_crc;
			end
		end
	end

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SHORT |-> pkt_id == '0 && ack_checksum == '0)
		else $error("short verdict with nonzero fields");

	a_ack_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_SHORT |-> ack_pkt_id[31])
		else $error("reply id without ack flag");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the datagram crc32c check and ack unit
//
// whole datagrams are streamed in one byte per transfer. a behavioral model
// kept inside the bench follows every accepted byte and queues the verdict
// that each final byte must produce. every verdict transfer is compared
// field by field with the oldest queued one. a short table of hand-built
// datagrams comes first, then random traffic under three idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
	import dcca_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUF_BYTES      = MAX_DATAGRAM_BYTES_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_REPORTS    = 10;
	localparam int PHASE_BYTES    = 240;
	localparam int PHASE_DGRAMS   = 8;

	// one verdict as it leaves the block
	typedef struct packed {
		status_t     status;
		logic [31:0] pid;
		logic [31:0] sid;
		logic [31:0] size;
		logic [31:0] ack_id;
		logic [31:0] ack_crc;
	} verdict_t;

	// verdict status fixed by hand for a table row
	typedef struct packed {
		logic    fixed;
		status_t status;
	} pinned_status_t;

	// hand-built datagram
	typedef struct {
		int          len;
		logic [31:0] pid;
		logic [31:0] sid;
		logic [31:0] size;
		bit          good;
		int          fill;   // payload byte value, negative for random
		bit          fixed;
		status_t     status;
	} dgram_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = 8'd0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	datagram_crc32c_check_and_ack_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	// datagram tracking state of the bench model
	int          kept_bytes = 0;
	logic [31:0] hdr_word [4] = '{default: 32'd0};
	logic [31:0] check_crc = 32'hFFFF_FFFF;
	logic [31:0] reply_crc = 32'hFFFF_FFFF;

	verdict_t       pending_verdicts [$];
	pinned_status_t pinned_statuses [$];

	int gap_pct = 0;
	int stall_pct = 0;
	int idle_run = 0;
	int miss_count = 0;
	int bytes_accepted = 0;
	int bytes_offered = 0;
	int dgrams_sent = 0;
	int verdict_seen [6] = '{default: 0};

	dgram_row_t directed_rows [12] = '{
		// lone byte right after reset
		'{1,    32'hFF00_0000, 32'h0000_0000, 32'h0000_0000, 1, -1,  1, ST_SHORT},
		// one byte short of a header
		'{15,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 0,   1, ST_SHORT},
		// bare header, empty payload
		'{16,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 0,   1, ST_ACK_NEEDED},
		'{16,   32'h4000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 1, 0,   1, ST_NOACK},
		'{20,   32'h8000_0000, 32'h0000_0000, 32'h0000_0004, 1, 255, 1, ST_ACK_RCVD},
		'{24,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0008, 1, 255, 1, ST_ACK_RCVD},
		'{19,   32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0003, 0, -1,  1, ST_CRC_BAD},
		// crc failure wins over the ack flag
		'{20,   32'h8000_0000, 32'h0000_0001, 32'h0000_0004, 0, -1,  1, ST_CRC_BAD},
		'{21,   32'h0000_0001, 32'h0000_0002, 32'h0000_0008, 1, -1,  1, ST_TRUNC},
		'{20,   32'h4000_0000, 32'h0000_0003, 32'hFFFF_FFFF, 1, -1,  1, ST_TRUNC},
		// trailing bytes past the payload, counted but outside the crc
		'{24,   32'h0ABC_DEF0, 32'h0000_0004, 32'h0000_0002, 1, -1,  0, ST_SHORT},
		'{17,   32'h3FFF_FFFF, 32'h0000_0007, 32'h0000_0001, 1, 0,   0, ST_SHORT}
	};

	function automatic logic [31:0] crc32c_byte(input logic [31:0] acc, input logic [7:0] b);
		acc ^= {24'd0, b};
		for (int k = 0; k < 8; k++)
			acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
		return acc;
	endfunction

	// follow one accepted byte, queue a verdict on the final one
	task automatic track_byte(input logic [7:0] b, input logic fin);
		verdict_t       v;
		pinned_status_t pin;
		logic [31:0]    r;
		if (kept_bytes < BUF_BYTES) begin
			if (kept_bytes < HEADER_BYTES) begin
				hdr_word[kept_bytes >> 2] = {hdr_word[kept_bytes >> 2][23:0], b};
				if (kept_bytes < 8 || kept_bytes >= 12)
					check_crc = crc32c_byte(check_crc, b);
				// reply header carries the ack flag in its first byte
				if (kept_bytes < 8)
					reply_crc = crc32c_byte(reply_crc, kept_bytes == 0 ? (b | 8'h80) : b);
			end else if (longint'(kept_bytes - HEADER_BYTES) < longint'(hdr_word[3])) begin
				check_crc = crc32c_byte(check_crc, b);
			end
			kept_bytes++;
		end
		if (!fin)
			return;

		r = reply_crc;
		repeat (4) r = crc32c_byte(r, 8'h00);
		v.pid     = hdr_word[0];
		v.sid     = hdr_word[1];
		v.size    = hdr_word[3];
		v.ack_id  = hdr_word[0] | ACK_FLAG;
		v.ack_crc = ~r;
		if (kept_bytes < HEADER_BYTES) begin
			v = '0;
			v.status = ST_SHORT;
		end else if (longint'(hdr_word[3]) + HEADER_BYTES > longint'(kept_bytes)) begin
			v.status = ST_TRUNC;
		end else if (~check_crc != hdr_word[2]) begin
			v.status = ST_CRC_BAD;
		end else if ((hdr_word[0] & ACK_FLAG) != 0) begin
			v.status = ST_ACK_RCVD;
		end else if ((hdr_word[0] & NOACK_FLAG) == 0) begin
			v.status = ST_ACK_NEEDED;
		end else begin
			v.status = ST_NOACK;
		end

		pin = pinned_statuses.pop_front();
		if (pin.fixed)
			v.status = pin.status;
		pending_verdicts.push_back(v);

		kept_bytes = 0;
		hdr_word   = '{default: 32'd0};
		check_crc  = 32'hFFFF_FFFF;
		reply_crc  = 32'hFFFF_FFFF;
	endtask

	task automatic log_miss(input string what, input logic [31:0] want, input logic [31:0] got);
		miss_count++;
		if (miss_count <= MAX_REPORTS)
			$display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	task automatic check_verdict(input logic [OUT_TDATA_W-1:0] d);
		verdict_t want;
		if (d[2:0] <= ST_NOACK)
			verdict_seen[d[2:0]]++;
		if (pending_verdicts.size() == 0) begin
			log_miss("verdict with none pending, status", 32'd0, 32'(d[2:0]));
			return;
		end
		want = pending_verdicts.pop_front();
		if (d[2:0] != want.status)
			log_miss("status", 32'(want.status), 32'(d[2:0]));
		if (d[34:3] != want.pid)
			log_miss("pkt_id", want.pid, d[34:3]);
		if (d[66:35] != want.sid)
			log_miss("seq_id", want.sid, d[66:35]);
		if (d[98:67] != want.size)
			log_miss("declared_size", want.size, d[98:67]);
		if (d[130:99] != want.ack_id)
			log_miss("ack_pkt_id", want.ack_id, d[130:99]);
		if (d[162:131] != want.ack_crc)
			log_miss("ack_checksum", want.ack_crc, d[162:131]);
		if (d[OUT_TDATA_W-1:163] != '0)
			log_miss("zero fill", 32'd0, 32'(d[OUT_TDATA_W-1:163]));
	endtask

	// transfer monitor and watchdog, sampled at the rising edge
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			track_byte(s_axis_tdata, s_axis_tlast);
			bytes_accepted++;
		end
		if (m_axis_tvalid && m_axis_tready)
			check_verdict(m_axis_tdata);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_run = 0;
		else
			idle_run++;
		if (idle_run >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver side back-pressure
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	// called and returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input bit fin);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= fin;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic send_datagram(input int len, input logic [31:0] pid, input logic [31:0] sid,
			input logic [31:0] size, input bit good, input int fill, input bit fixed,
			input status_t status);
		logic [7:0]     dg [$];
		logic [127:0]   hdr_bits;
		logic [31:0]    sum;
		pinned_status_t pin;
		hdr_bits = {pid, sid, 32'd0, size};
		for (int i = 0; i < len; i++) begin
			if (i < HEADER_BYTES)
				dg.push_back(hdr_bits[127 - 8 * i -: 8]);
			else
				dg.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
		end
		// checksum word over header bytes 0-7, 12-15 and the declared payload
		sum = 32'hFFFF_FFFF;
		for (int i = 0; i < len && longint'(i) < longint'(size) + HEADER_BYTES; i++)
			if (i < 8 || i >= 12)
				sum = crc32c_byte(sum, dg[i]);
		sum = ~sum;
		if (!good)
			sum ^= 32'd1 << $urandom_range(31);
		for (int i = 8; i < 12 && i < len; i++)
			dg[i] = sum[31 - 8 * (i - 8) -: 8];
		pin.fixed  = fixed;
		pin.status = status;
		pinned_statuses.push_back(pin);
		foreach (dg[i])
			send_byte(dg[i], i == len - 1);
		bytes_offered += len;
		dgrams_sent++;
	endtask

	// mostly well-formed datagrams, the rest damaged or cut short
	task automatic send_random_datagram();
		int          pick;
		int          len;
		logic [31:0] size;
		bit          good;
		pick = $urandom_range(99);
		good = 1;
		size = $urandom_range(24);
		len  = 16 + size;
		if (pick < 65) begin
			if ($urandom_range(3) == 0)
				len += $urandom_range(1, 6);
		end else if (pick < 77) begin
			good = 0;
		end else if (pick < 87) begin
			size = $urandom_range(1, 24);
			len  = $urandom_range(16, 15 + size);
		end else if (pick < 92) begin
			size = $urandom | 32'h0000_1000;
			len  = $urandom_range(16, 40);
		end else begin
			len = $urandom_range(1, 15);
		end
		send_datagram(len, $urandom, $urandom, size, good, -1, 0, ST_SHORT);
	endtask

	// sender holds off until every verdict is back
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int start_bytes;
		int start_dgrams;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < 3; phase++) begin
			gap_pct   = (phase == 0) ? 27 : (phase == 1) ? 77 : 0;
			stall_pct = (phase == 0) ? 77 : (phase == 1) ? 27 : 0;
			if (phase == 0)
				foreach (directed_rows[i])
					send_datagram(directed_rows[i].len, directed_rows[i].pid,
						directed_rows[i].sid, directed_rows[i].size, directed_rows[i].good,
						directed_rows[i].fill, directed_rows[i].fixed, directed_rows[i].status);
			start_bytes  = bytes_offered;
			start_dgrams = dgrams_sent;
			while (bytes_offered - start_bytes < PHASE_BYTES ||
					dgrams_sent - start_dgrams < PHASE_DGRAMS)
				send_random_datagram();
			hold_until_drained();
		end

		$display("covered %0d bytes in %0d datagrams", bytes_accepted, dgrams_sent);
		$display("table rows, then random traffic under three idle mixes");
		$display("verdicts: short %0d, truncated %0d, crc bad %0d,",
			verdict_seen[ST_SHORT], verdict_seen[ST_TRUNC], verdict_seen[ST_CRC_BAD]);
		$display("          ack rcvd %0d, ack needed %0d, no-ack %0d",
			verdict_seen[ST_ACK_RCVD], verdict_seen[ST_ACK_NEEDED], verdict_seen[ST_NOACK]);
		if (miss_count == 0 && pending_verdicts.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d verdicts outstanding", miss_count,
				pending_verdicts.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[files.f]
rtl/dcca_pkg.sv
rtl/dcca_crc_byte.sv
rtl/dcca_rx_state.sv
rtl/dcca_verdict.sv
rtl/datagram_crc32c_check_and_ack_unit.sv
tb/tb_top.sv
